@@ rtl/core/bni_pkg.sv @@
`timescale 1ns / 1ps
package bni_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int EPS_W     = 16;
  localparam int MAX_CH    = 256;
  localparam int TAB_AW    = $clog2(MAX_CH);
  localparam int CH_W      = 8;
  localparam int CNT_W     = 9;

  localparam int ADDR_W    = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CH_COUNT  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SKIP_ROOT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_EPSILON   = REG_IDX_W'(2);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam int SUM_W      = ((DATA_W > EPS_W) ? DATA_W : EPS_W) + 1;
  localparam int RAD_W      = ((SUM_W + FRAC_BITS + 1) / 2) * 2;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int DIFF_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int Q_W        = DATA_W + 1;
  localparam int HI_W       = PROD_W - Q_W;
  localparam int REM_W      = DATA_W + 1;
  localparam int Y_W        = Q_W + 2;
  localparam int STEP_CNT_W = $clog2(Q_W);

  localparam logic [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [Q_W-1:0]    Q_CAP = {1'b1, {DATA_W{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_SQRT,
    S_CHECK,
    S_DIV,
    S_FINAL
  } state_e;

  typedef enum logic [1:0] {
    STEP_SQRT,
    STEP_DIV,
    STEP_CHECK
  } step_mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] scale;
    logic [DATA_W-1:0] bias;
    logic [DATA_W-1:0] mean;
    logic [DATA_W-1:0] variance;
  } chan_par_t;

endpackage

@@ rtl/core/bni_ram.sv @@
`timescale 1ns / 1ps
module bni_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bni_step_unit.sv @@
`timescale 1ns / 1ps
// Shared compare-subtract: one root digit, one quotient bit, or the quotient range check.
module bni_step_unit import bni_pkg::*; (
  input  step_mode_e         mode_i,
  input  logic [REM_W-1:0]   rem_i,
  input  logic [1:0]         pair_i,
  input  logic               bit_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  logic [DATA_W-1:0]  divisor_i,
  input  logic [HI_W-1:0]    high_i,
  output logic [REM_W-1:0]   rem_o,
  output logic               ge_o
);

  logic [REM_W-1:0] op_a;
  logic [REM_W-1:0] op_b;
  logic [REM_W:0]   diff;

  always_comb begin
    case (mode_i)
      STEP_SQRT: begin
        op_a = {rem_i[REM_W-3:0], pair_i};
        op_b = REM_W'({root_i, 2'b01});
      end
      STEP_DIV: begin
        op_a = {rem_i[REM_W-2:0], bit_i};
        op_b = REM_W'(divisor_i);
      end
      STEP_CHECK: begin
        op_a = REM_W'(high_i);
        op_b = REM_W'(divisor_i);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff  = {1'b0, op_a} - {1'b0, op_b};
  assign ge_o  = ~diff[REM_W];
  assign rem_o = ge_o ? diff[REM_W-1:0] : op_a;

endmodule

@@ rtl/core/batch_norm_inference.sv @@
`timescale 1ns / 1ps
// channel  handshake                    payload
// in       in_valid_i / in_stall_o      op, channel, scale_in, bias_in, mean_in,
//                                       variance_in, sample, last_element
// out      out_valid_o / out_stall_i    normalized, saturated, last_out
// cfg      psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// A load word is written while idle. A data word runs the shared
// compare-subtract unit: 13 root digits (none with skip_root), then 17
// quotient bits, skipped if the divisor is zero or the quotient overflows.
// Reset is async; the parameter tables are not cleared.
// A finished result waits in the output register; the next word is taken
// meanwhile, and a second result holds in the final state until it drains.
module batch_norm_inference import bni_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [CH_W-1:0]          channel_i,
  input  logic signed [DATA_W-1:0] scale_in_i,
  input  logic signed [DATA_W-1:0] bias_in_i,
  input  logic signed [DATA_W-1:0] mean_in_i,
  input  logic [DATA_W-1:0]        variance_in_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     last_element_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] normalized_o,
  output logic                     saturated_o,
  output logic                     last_out_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]  ch_count_q;
  logic              skip_root_q;
  logic [EPS_W-1:0]  epsilon_q;
  logic [TAB_AW-1:0] pos_q;

  logic in_acc, data_acc, load_acc, cfg_wr, out_free;
  logic ram_re;
  step_mode_e step_mode;

  chan_par_t ram_wdata, ram_rdata;

  logic [DATA_W-1:0]  sample_q;
  logic               last_q;
  logic [DATA_W-1:0]  gmag_q;
  logic [DIFF_W-1:0]  dmag_q;
  logic               sign_q;
  logic               neg_q;
  logic [DATA_W-1:0]  beta_q;
  logic [DATA_W-1:0]  var_q;
  logic [RAD_W-1:0]   rad_q;
  logic [PROD_W-1:0]  prod_q;
  logic [REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [Q_W-1:0]     num_q;
  logic [Q_W-1:0]     q_q;
  logic               zero_q;
  logic [STEP_CNT_W-1:0] cnt_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] normalized_q;
  logic              saturated_q;
  logic              last_out_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign data_acc = in_acc && (op_i == OP_DATA);
  assign load_acc = in_acc && (op_i == OP_LOAD)
                    && ({1'b0, channel_i} < (CH_W+1)'(MAX_CH));
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_q || !out_stall_i;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_count_q  <= CNT_W'(1);
      skip_root_q <= 1'b0;
      epsilon_q   <= EPS_W'(1);
    end else if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_CH_COUNT:  ch_count_q  <= pwdata[CNT_W-1:0];
        REG_SKIP_ROOT: skip_root_q <= pwdata[0];
        REG_EPSILON:   epsilon_q   <= pwdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_CH_COUNT:  prdata = PDATA_W'(ch_count_q);
      REG_SKIP_ROOT: prdata = PDATA_W'(skip_root_q);
      REG_EPSILON:   prdata = PDATA_W'(epsilon_q);
      default:       prdata = '0;
    endcase
  end

  // element position
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] pos_inc;

  always_comb begin
    if (ch_count_q == '0) begin
      count_eff = CNT_W'(1);
    end else if (ch_count_q > CNT_W'(MAX_CH)) begin
      count_eff = CNT_W'(MAX_CH);
    end else begin
      count_eff = ch_count_q;
    end
    pos_inc = CNT_W'(pos_q) + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (data_acc) begin
      if (last_element_i || (pos_inc >= count_eff)) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_inc[TAB_AW-1:0];
      end
    end
  end

  // parameter tables
  assign ram_wdata = '{scale:    scale_in_i,
                       bias:     bias_in_i,
                       mean:     mean_in_i,
                       variance: variance_in_i};

  bni_ram #(
    .WIDTH ($bits(chan_par_t)),
    .DEPTH (MAX_CH)
  ) u_tables (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (channel_i[TAB_AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // sequencer
  logic [DATA_W-1:0] dvs;
  logic [REM_W-1:0]  unit_rem;
  logic              unit_ge;
  logic [PROD_W-1:0] num_chk;

  assign dvs     = skip_root_q ? var_q : DATA_W'(root_q);
  assign num_chk = prod_q + PROD_W'(dvs >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (data_acc) state_d = S_FETCH;
      S_FETCH: state_d = S_MUL;
      S_MUL:   state_d = skip_root_q ? S_CHECK : S_SQRT;
      S_SQRT:  if (cnt_q == '0) state_d = S_CHECK;
      S_CHECK: begin
        if ((dvs == '0) || unit_ge) begin
          state_d = S_FINAL;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:   if (cnt_q == '0) state_d = S_FINAL;
      S_FINAL: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    step_mode  = STEP_DIV;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_valid_i && (op_i == OP_DATA);
      end
      S_SQRT:  step_mode = STEP_SQRT;
      S_CHECK: step_mode = STEP_CHECK;
      default: ;
    endcase
  end

  bni_step_unit u_step (
    .mode_i    (step_mode),
    .rem_i     (rem_q),
    .pair_i    (rad_q[RAD_W-1 -: 2]),
    .bit_i     (num_q[Q_W-1]),
    .root_i    (root_q),
    .divisor_i (dvs),
    .high_i    (num_chk[PROD_W-1 -: HI_W]),
    .rem_o     (unit_rem),
    .ge_o      (unit_ge)
  );

  // datapath
  logic signed [DIFF_W-1:0]  diff_s;
  logic [DIFF_W-1:0]         diff_mag;
  logic [DATA_W-1:0]         g_mag;
  logic [SUM_W-1:0]          var_sum;
  logic [DATA_W+DIFF_W-1:0]  prod_full;

  always_comb begin
    diff_s   = $signed({sample_q[DATA_W-1], sample_q})
               - $signed({ram_rdata.mean[DATA_W-1], ram_rdata.mean});
    diff_mag = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);
    g_mag    = ram_rdata.scale[DATA_W-1] ? (DATA_W'(0) - ram_rdata.scale)
                                         : ram_rdata.scale;
    var_sum  = SUM_W'(ram_rdata.variance) + SUM_W'(epsilon_q);
    prod_full = gmag_q * dmag_q;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (data_acc) begin
          sample_q <= sample_i;
          last_q   <= last_element_i;
        end
      end
      S_FETCH: begin
        gmag_q <= g_mag;
        dmag_q <= diff_mag;
        sign_q <= ram_rdata.scale[DATA_W-1] ^ diff_s[DIFF_W-1];
        beta_q <= ram_rdata.bias;
        var_q  <= ram_rdata.variance;
        rad_q  <= RAD_W'({var_sum, {FRAC_BITS{1'b0}}});
      end
      S_MUL: begin
        prod_q <= prod_full[PROD_W-1:0];
        neg_q  <= sign_q && (prod_full != '0);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= STEP_CNT_W'(ROOT_W - 1);
      end
      S_SQRT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= unit_rem;
        root_q <= {root_q[ROOT_W-2:0], unit_ge};
        cnt_q  <= cnt_q - STEP_CNT_W'(1);
      end
      S_CHECK: begin
        zero_q <= (dvs == '0);
        rem_q  <= unit_rem;
        num_q  <= num_chk[Q_W-1:0];
        q_q    <= unit_ge ? Q_CAP : '0;
        cnt_q  <= STEP_CNT_W'(Q_W - 1);
      end
      S_DIV: begin
        num_q <= num_q << 1;
        rem_q <= unit_rem;
        q_q   <= {q_q[Q_W-2:0], unit_ge};
        cnt_q <= cnt_q - STEP_CNT_W'(1);
      end
      default: ;
    endcase
  end

  // final add and clip
  logic [Q_W-1:0]           q_clip;
  logic signed [Q_W:0]      q_signed;
  logic signed [Y_W-1:0]    y_sum;
  logic                     y_fits;
  logic [DATA_W-1:0]        y_val;
  logic                     y_sat;

  always_comb begin
    q_clip   = (q_q > Q_CAP) ? Q_CAP : q_q;
    q_signed = neg_q ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
    y_sum    = Y_W'(q_signed) + Y_W'($signed(beta_q));
    y_fits   = (y_sum[Y_W-1:DATA_W-1] == '0) || (y_sum[Y_W-1:DATA_W-1] == '1);
    if (zero_q) begin
      y_val = neg_q ? Y_MIN : Y_MAX;
      y_sat = 1'b1;
    end else if (y_fits) begin
      y_val = y_sum[DATA_W-1:0];
      y_sat = 1'b0;
    end else begin
      y_val = y_sum[Y_W-1] ? Y_MIN : Y_MAX;
      y_sat = 1'b1;
    end
  end

  // output register
  logic load_out;
  assign load_out = (state_q == S_FINAL) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      normalized_q <= y_val;
      saturated_q  <= y_sat;
      last_out_q   <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normalized_o = $signed(normalized_q);
  assign saturated_o  = saturated_q;
  assign last_out_o   = last_out_q;

endmodule

@@ rtl/core/bni_checker.sv @@
`timescale 1ns / 1ps
module bni_checker import bni_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     op_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] normalized_o,
  input logic                     saturated_o
);

  // a data word keeps the block busy
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_DATA) |=> in_stall_o)
    else $error("input not stalled after data word");

  // a load word never yields a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("result after load word");

  // flagged results sit at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (normalized_o == $signed(Y_MAX)) || (normalized_o == $signed(Y_MIN)))
    else $error("saturated result not at a limit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(normalized_o))
    else $error("stalled result changed");

endmodule

bind batch_norm_inference bni_checker u_bni_checker (.*);
